>>> rtl/tkh_pkg.sv
// Shared types, constants and helper functions for the markup token highlighter.
// No dependencies; all other rtl files import this package.
package tkh_pkg;

   // Source position / length width and comment nesting counter width
   localparam int POSITION_BITS = 32;
   localparam int DEPTH_BITS    = 16;

   // Port field width for token begin / length
   localparam int OUT_BITS = 32;

   // At most three tokens leave per instruction
   localparam int MAX_RESULTS = 3;
   localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);

   // Result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [DEPTH_BITS-1:0]    depth_type;

   localparam pos_type   POS_ONE   = pos_type'(1);
   localparam depth_type DEPTH_ONE = depth_type'(1);

   // Parse-tree instruction codes
   typedef enum logic [3:0] {
      CMD_PUSH_DOC,
      CMD_POP_DOC,
      CMD_PUSH_DIR,
      CMD_POP_DIR,
      CMD_PUSH_ARGS,
      CMD_POP_ARGS,
      CMD_COMMA,
      CMD_EQUAL,
      CMD_PUSH_ARG,
      CMD_POP_ARG,
      CMD_ARG_NAME,
      CMD_PUSH_BLOCK,
      CMD_POP_BLOCK,
      CMD_SKIP,
      CMD_ESCAPE,
      CMD_TEXT
   } cmd_type;

   // Highlight kinds
   typedef enum logic [2:0] {
      KIND_ESCAPE,
      KIND_ATTR,
      KIND_TAG,
      KIND_SYM,
      KIND_SQUARE,
      KIND_BRACE,
      KIND_COMMENT,
      KIND_DELIM
   } kind_type;

   // One outgoing token as it travels on the result channel
   typedef struct packed {
      logic [OUT_BITS-1:0] start;
      logic [OUT_BITS-1:0] length;
      kind_type            kind;
      logic                last;
   } result_type;

   // Held-back token plus the running source position
   typedef struct packed {
      logic     valid;
      pos_type  start;
      pos_type  length;
      kind_type kind;
      pos_type  position;
   } pend_type;

   // Outcome of offering one token to the pending slot
   typedef struct packed {
      pend_type   pend;
      logic       sent;
      result_type tok;
   } emit_type;

   // Tokens handed from the core to the result queue in one cycle
   typedef struct packed {
      logic [COUNT_BITS-1:0]             count;
      result_type [MAX_RESULTS-1:0]      tok;
   } push_type;

   // Keep the low port-width bits of a position value
   function automatic logic [OUT_BITS-1:0] to_out(pos_type x);
      logic [63:0] wide;
      wide = 64'(x);
      return wide[OUT_BITS-1:0];
   endfunction

   // Pending slot as an outgoing token
   function automatic result_type pend_token(pend_type p);
      result_type t;
      t.start  = to_out(p.start);
      t.length = to_out(p.length);
      t.kind   = p.kind;
      t.last   = 1'b0;
      return t;
   endfunction

   // Offer a token of len characters at the current position: merge it into the
   // pending one when allowed, else push the pending one out and take its place.
   function automatic emit_type emit_token(pend_type p, logic coalesce, pos_type len,
                                           kind_type kind);
      emit_type r;
      pos_type  pend_end;
      pend_end = p.start + p.length;
      r.pend   = p;
      r.sent   = 1'b0;
      r.tok    = pend_token(p);
      if (len != '0) begin
         if (coalesce && p.valid && (p.kind == kind) && (pend_end == p.position) &&
             (len <= ~p.length)) begin
            r.pend.length = p.length + len;
         end else begin
            r.sent        = p.valid;
            r.pend.valid  = 1'b1;
            r.pend.start  = p.position;
            r.pend.length = len;
            r.pend.kind   = kind;
         end
         r.pend.position = p.position + len;
      end
      return r;
   endfunction

endpackage

>>> rtl/markup_token_highlighter_unit.sv
// A token passes the core's input register and is then written into the result queue
// before it is valid on rsp_; the core holds an instruction while the queue lacks room.
// Throughput: one instruction per cycle while each yields at most one token and
// rsp_tready stays high; an instruction yielding several tokens sends them one per
// transaction from the four-entry result queue, which takes new tokens only while it holds at most one.
// Reset (synchronous, active high) clears position, comment state, pending token,
// coalesce_enable and the queue.
module markup_token_highlighter_unit
   import tkh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wen,
   input  logic        csr_wdata,      // coalesce_enable
   // instruction stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,      // [3:0] command, [35:4] span_length, [39:36] zero
   input  logic        req_tuser,      // names_comment
   input  logic        req_tlast,      // end_of_stream
   // token stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,      // [31:0] token_begin, [63:32] token_length
   output logic [2:0]  rsp_tuser,      // token_kind
   output logic        rsp_tlast       // last_of_run
);

   logic       coalesce_ff;
   logic       room;
   push_type   push;
   result_type res;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         coalesce_ff <= 1'b0;
      end else if (csr_wen) begin
         coalesce_ff <= csr_wdata;
      end
   end

   tkh_core u_core (
      .clock            (clock),
      .reset            (reset),
      .coalesce         (coalesce_ff),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_command       (cmd_type'(req_tdata[3:0])),
      .in_span          (req_tdata[35:4]),
      .in_names_comment (req_tuser),
      .in_eos           (req_tlast),
      .room             (room),
      .push             (push)
   );

   tkh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   // result packing
   assign rsp_tdata = {res.length, res.start};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

>>> rtl/tkh_queue.sv
// Result queue: takes up to three tokens per cycle, hands out one per transaction.
// Depends on tkh_pkg.
module tkh_queue
   import tkh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]        count_ff, count_in;
   logic                     pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // enough free slots for the largest burst from one instruction
   assign room      = (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - MAX_RESULTS));

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      count_in  = count_ff + (QUEUE_AW+1)'(push.count) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (COUNT_BITS'(i) < push.count) begin
            mem_ff[wr_ptr_ff + QUEUE_AW'(i)] <= push.tok[i];
         end
      end
   end

endmodule

>>> rtl/tkh_core.sv
// Input register, highlighter state and the per-instruction update logic.
// Depends on tkh_pkg.
module tkh_core
   import tkh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                coalesce,
   input  logic                in_valid,
   output logic                in_ready,
   input  cmd_type             in_command,
   input  logic [OUT_BITS-1:0] in_span,
   input  logic                in_names_comment,
   input  logic                in_eos,
   input  logic                room,
   output push_type            push
);

   // input register
   logic                in_valid_ff;
   cmd_type             cmd_ff;
   logic [OUT_BITS-1:0] span_ff;
   logic                comment_ff;
   logic                eos_ff;

   // highlighter state
   pend_type  pend_ff, pend_in;
   depth_type depth_ff, depth_in;
   pos_type   delim_ff, delim_in;
   pos_type   content_ff, content_in;

   logic      fire;
   logic      take;

   // working values
   logic [63:0]           span_wide;
   pos_type               n;
   pend_type              p;
   pos_type               len1, len2;
   kind_type              kind1;
   emit_type              e1, e2;
   logic [COUNT_BITS-1:0] nres;
   result_type [MAX_RESULTS-1:0] res;

   assign fire     = in_valid_ff && room;
   assign in_ready = !in_valid_ff || fire;
   assign take     = in_valid && in_ready;

   // next state and outgoing tokens for the registered instruction
   always_comb begin
      span_wide  = 64'(span_ff);
      n          = span_wide[POSITION_BITS-1:0];
      p          = pend_ff;
      depth_in   = depth_ff;
      delim_in   = delim_ff;
      content_in = content_ff;
      len1       = '0;
      len2       = '0;
      kind1      = KIND_ESCAPE;

      if (depth_ff != '0) begin
         // inside a comment directive
         unique case (cmd_ff)
            CMD_PUSH_DIR, CMD_ARG_NAME, CMD_SKIP, CMD_ESCAPE, CMD_TEXT: begin
               if (depth_ff > DEPTH_ONE) content_in = content_ff + n;
               else delim_in = delim_ff + n;
            end
            CMD_POP_DIR: begin
               // comment without a block: flush delimiter characters here
               if (depth_ff == DEPTH_ONE) begin
                  len1     = delim_ff;
                  kind1    = KIND_DELIM;
                  delim_in = '0;
                  depth_in = '0;
               end
            end
            CMD_PUSH_ARGS, CMD_POP_ARGS, CMD_COMMA, CMD_EQUAL: begin
               if (depth_ff > DEPTH_ONE) content_in = content_ff + POS_ONE;
               else delim_in = delim_ff + POS_ONE;
            end
            CMD_PUSH_BLOCK: begin
               if (depth_ff > DEPTH_ONE) begin
                  content_in = content_ff + POS_ONE;
               end else begin
                  len1     = delim_ff + POS_ONE;
                  kind1    = KIND_DELIM;
                  delim_in = '0;
               end
               if (depth_ff != '1) depth_in = depth_ff + DEPTH_ONE;
            end
            CMD_POP_BLOCK: begin
               depth_in = depth_ff - DEPTH_ONE;
               if (depth_in == DEPTH_ONE) begin
                  len1       = content_ff;
                  kind1      = KIND_COMMENT;
                  content_in = '0;
                  len2       = POS_ONE;
               end else begin
                  content_in = content_ff + POS_ONE;
               end
            end
            default: ;
         endcase
      end else begin
         // plain markup
         unique case (cmd_ff)
            CMD_SKIP, CMD_TEXT: p.position = pend_ff.position + n;
            CMD_ESCAPE: begin
               len1  = n;
               kind1 = KIND_ESCAPE;
            end
            CMD_ARG_NAME: begin
               len1  = n;
               kind1 = KIND_ATTR;
            end
            CMD_PUSH_DIR: begin
               if (comment_ff) begin
                  depth_in   = DEPTH_ONE;
                  delim_in   = n;
                  content_in = '0;
               end else begin
                  len1  = n;
                  kind1 = KIND_TAG;
               end
            end
            CMD_COMMA, CMD_EQUAL: begin
               len1  = POS_ONE;
               kind1 = KIND_SYM;
            end
            CMD_PUSH_ARGS, CMD_POP_ARGS: begin
               len1  = POS_ONE;
               kind1 = KIND_SQUARE;
            end
            CMD_PUSH_BLOCK, CMD_POP_BLOCK: begin
               len1  = POS_ONE;
               kind1 = KIND_BRACE;
            end
            default: ;
         endcase
      end

      // at most two token offers per instruction
      e1 = emit_token(p, coalesce, len1, kind1);
      e2 = emit_token(e1.pend, coalesce, len2, KIND_DELIM);
      pend_in = e2.pend;

      // collect outgoing tokens in order
      nres = '0;
      res  = {MAX_RESULTS{e1.tok}};
      if (e1.sent) begin
         res[nres] = e1.tok;
         nres      = nres + COUNT_BITS'(1);
      end
      if (e2.sent) begin
         res[nres] = e2.tok;
         nres      = nres + COUNT_BITS'(1);
      end
      // end of stream flushes the pending token
      if (eos_ff && pend_in.valid) begin
         res[nres]     = pend_token(pend_in);
         nres          = nres + COUNT_BITS'(1);
         pend_in.valid = 1'b0;
      end
      if (nres != '0) res[nres - COUNT_BITS'(1)].last = 1'b1;

      push.tok   = res;
      push.count = fire ? nres : '0;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff     <= in_command;
         span_ff    <= in_span;
         comment_ff <= in_names_comment;
         eos_ff     <= in_eos;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         depth_ff   <= '0;
         delim_ff   <= '0;
         content_ff <= '0;
      end else if (fire) begin
         pend_ff    <= pend_in;
         depth_ff   <= depth_in;
         delim_ff   <= delim_in;
         content_ff <= content_in;
      end
   end

endmodule
